FILE: hw/rtl/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg: shared types and constants for the height grid smoothing block
// Grid geometry, operation codes and the command passed to the grid walker.
// ----------------------------------------------------------------------------
`default_nettype none
package hns_pkg;
   localparam int GRID_X   = 512;
   localparam int GRID_Z   = 512;
   localparam int XW       = 9;   // field width of col_x
   localparam int ZW       = 9;   // field width of row_z
   localparam int AW       = XW + ZW;
   localparam int DEPTH    = GRID_X * GRID_Z;
   localparam int HW       = 16;
   localparam int SW       = 10;  // size register width

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SMOOTH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Z = 2'd1;
   localparam logic [1:0] REG_PASSES = 2'd2;
   localparam logic [1:0] REG_CUT    = 2'd3;

   typedef struct packed {
      logic [SW-1:0] nx;
      logic [SW-1:0] nz;
      logic [3:0]    passes;
      logic [HW-1:0] cut;
   } walk_cfg_type;
endpackage
`default_nettype wire

FILE: hw/rtl/hns_ram.sv
// ----------------------------------------------------------------------------
// hns_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module hns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/hns_walker.sv
// ----------------------------------------------------------------------------
// hns_walker: grid walk sequencer
// Runs the in-place smoothing passes and the threshold cut over the RAM
// through its single port. Per interior cell: read centre; if nonzero, read
// eight neighbours and write back. Cut: read, then write if below threshold.
// ----------------------------------------------------------------------------
`default_nettype none
module hns_walker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire hns_pkg::walk_cfg_type    cfg,
   input  wire logic [hns_pkg::HW-1:0]   rd_data,
   output logic                          busy,
   output logic                          finish,
   output logic                          wr_en,
   output logic [hns_pkg::AW-1:0]        addr,
   output logic [hns_pkg::HW-1:0]        wr_data
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CENTRE = 3'd1;
   localparam logic [2:0] S_NEIGH  = 3'd2;
   localparam logic [2:0] S_WBACK  = 3'd3;
   localparam logic [2:0] S_CREAD  = 3'd4;
   localparam logic [2:0] S_CWAIT  = 3'd5;
   localparam logic [2:0] S_CWRITE = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [hns_pkg::XW-1:0]  x_ff, x_in;
   logic [hns_pkg::ZW-1:0]  z_ff, z_in;
   logic [3:0]              pass_ff, pass_in;
   logic [3:0]              step_ff, step_in;   // 0 centre wait, 1..8 neighbours
   logic [18:0]             sum_ff, sum_in;
   logic [hns_pkg::SW-1:0]  nx, nz;
   logic                    interior;
   logic [hns_pkg::XW-1:0]  nb_x;
   logic [hns_pkg::ZW-1:0]  nb_z;
   logic [hns_pkg::SW-1:0]  x_ext, z_ext;
   logic                    last_x_int, last_z_int, last_x, last_z;

   always_comb begin
      nx = (cfg.nx > hns_pkg::SW'(hns_pkg::GRID_X)) ? hns_pkg::SW'(hns_pkg::GRID_X) : cfg.nx;
      nz = (cfg.nz > hns_pkg::SW'(hns_pkg::GRID_Z)) ? hns_pkg::SW'(hns_pkg::GRID_Z) : cfg.nz;
      interior = (nx >= hns_pkg::SW'(3)) && (nz >= hns_pkg::SW'(3));
      x_ext = {1'b0, x_ff};
      z_ext = {1'b0, z_ff};
      last_x_int = (x_ext + hns_pkg::SW'(2)) >= nx;
      last_z_int = (z_ext + hns_pkg::SW'(2)) >= nz;
      last_x = (x_ext + hns_pkg::SW'(1)) >= nx;
      last_z = (z_ext + hns_pkg::SW'(1)) >= nz;
   end

   // neighbour address for the read issued in this cycle (step 0..7)
   always_comb begin
      nb_x = x_ff;
      nb_z = z_ff;
      case (step_ff[2:0])
         3'd0: begin nb_x = x_ff - 1'b1; nb_z = z_ff - 1'b1; end
         3'd1: begin nb_x = x_ff - 1'b1; nb_z = z_ff;        end
         3'd2: begin nb_x = x_ff - 1'b1; nb_z = z_ff + 1'b1; end
         3'd3: begin nb_x = x_ff;        nb_z = z_ff - 1'b1; end
         3'd4: begin nb_x = x_ff;        nb_z = z_ff + 1'b1; end
         3'd5: begin nb_x = x_ff + 1'b1; nb_z = z_ff - 1'b1; end
         3'd6: begin nb_x = x_ff + 1'b1; nb_z = z_ff;        end
         default: begin nb_x = x_ff + 1'b1; nb_z = z_ff + 1'b1; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      z_in     = z_ff;
      pass_in  = pass_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      wr_en    = 1'b0;
      addr     = {x_ff, z_ff};
      wr_data  = sum_ff[18:3];
      finish   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pass_in = '0;
               x_in = hns_pkg::XW'(1);
               z_in = hns_pkg::ZW'(1);
               if (cfg.passes != 4'd0 && interior) begin
                  state_in = S_CENTRE;
               end else begin
                  x_in = '0;
                  z_in = '0;
                  state_in = (nx != '0 && nz != '0) ? S_CREAD : S_DONE;
               end
            end
         end
         S_CENTRE: begin
            // centre read issued; neighbour 0 issued next cycle
            step_in  = '0;
            sum_in   = '0;
            state_in = S_NEIGH;
         end
         S_NEIGH: begin
            // step 0: centre data back; steps 1..8 neighbour data back
            addr = {nb_x, nb_z};
            if (step_ff == 4'd0 && rd_data == '0) begin
               state_in = S_WBACK;   // zero centre: skip, advance
               step_in  = 4'd15;
            end else begin
               if (step_ff != 4'd0) begin
                  sum_in = sum_ff + 19'(rd_data);
               end
               step_in = step_ff + 4'd1;
               if (step_ff == 4'd8) begin
                  state_in = S_WBACK;
               end
            end
         end
         S_WBACK: begin
            wr_en = (step_ff != 4'd15);
            if (!last_z_int) begin
               z_in = z_ff + 1'b1;
               state_in = S_CENTRE;
            end else if (!last_x_int) begin
               z_in = hns_pkg::ZW'(1);
               x_in = x_ff + 1'b1;
               state_in = S_CENTRE;
            end else if (pass_ff + 4'd1 < cfg.passes) begin
               pass_in = pass_ff + 4'd1;
               x_in = hns_pkg::XW'(1);
               z_in = hns_pkg::ZW'(1);
               state_in = S_CENTRE;
            end else begin
               x_in = '0;
               z_in = '0;
               state_in = S_CREAD;
            end
         end
         S_CREAD: begin
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            state_in = S_CWRITE;
         end
         S_CWRITE: begin
            wr_data = '0;
            wr_en = ({16'd0, rd_data} < {16'd0, cfg.cut}) ;
            if (!last_z) begin
               z_in = z_ff + 1'b1;
               state_in = S_CREAD;
            end else if (!last_x) begin
               z_in = '0;
               x_in = x_ff + 1'b1;
               state_in = S_CREAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // rd_data in S_CWRITE holds data read in S_CREAD (held since address unchanged)
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      z_ff    <= z_in;
      pass_ff <= pass_in;
      step_ff <= step_in;
      sum_ff  <= sum_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/heightmap_neighbor_smoothing.sv
// ----------------------------------------------------------------------------
// heightmap_neighbor_smoothing: height grid store with in-place smoothing
// Top level: request decode, RAM port arbitration and the response register.
// ----------------------------------------------------------------------------
// A cell write goes into the RAM as its request is taken; a cell read passes
// through the registered RAM output and a pending-read register into the
// response register. A new request is taken only once the last response has
// been taken. A smooth command runs over the single RAM port: per pass each
// nonzero interior cell costs a centre read, eight neighbour reads and a write
// back, a zero one only the centre read, and the cut reads every cell of the
// region in use. No request is taken while a smooth is running. Cells must be
// written before they are read or smoothed.
`default_nettype none
module heightmap_neighbor_smoothing (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [8:0]  req_col_x,
   input  wire logic [8:0]  req_row_z,
   input  wire logic [15:0] req_height_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_height_out,
   output logic             rsp_done_res,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   hns_pkg::walk_cfg_type cfg_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_h_ff, rsp_h_in;
   logic       rsp_done_ff, rsp_done_in;
   logic       rd_pend_ff, rd_pend_in;
   logic       smooth_ff, smooth_in;

   logic                   w_busy, w_finish, w_wr, w_start;
   logic [hns_pkg::AW-1:0] w_addr, ram_addr;
   logic [15:0]            w_data, ram_wdata, ram_rdata;
   logic                   ram_wr, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nx     <= 10'd512;
         cfg_ff.nz     <= 10'd512;
         cfg_ff.passes <= 4'd1;
         cfg_ff.cut    <= 16'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hns_pkg::REG_SIZE_X: cfg_ff.nx     <= csr_write_data[9:0];
            hns_pkg::REG_SIZE_Z: cfg_ff.nz     <= csr_write_data[9:0];
            hns_pkg::REG_PASSES: cfg_ff.passes <= csr_write_data[3:0];
            hns_pkg::REG_CUT:    cfg_ff.cut    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // block takes a request only when nothing is in flight and the output is free
   assign req_ready = !w_busy && !rd_pend_ff && !smooth_ff && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign w_start   = accept && (req_operation == hns_pkg::OP_SMOOTH);

   always_comb begin
      if (w_busy) begin
         ram_addr  = w_addr;
         ram_wr    = w_wr;
         ram_wdata = w_data;
      end else begin
         ram_addr  = {req_col_x, req_row_z};
         ram_wr    = accept && (req_operation == hns_pkg::OP_WRITE);
         ram_wdata = req_height_in;
      end
   end

   hns_ram #(.WIDTH(16), .DEPTH(hns_pkg::DEPTH)) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr),
      .addr       (ram_addr),
      .wr_data    (ram_wdata),
      .rd_data_ff (ram_rdata)
   );

   hns_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (w_start),
      .cfg     (cfg_ff),
      .rd_data (ram_rdata),
      .busy    (w_busy),
      .finish  (w_finish),
      .wr_en   (w_wr),
      .addr    (w_addr),
      .wr_data (w_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_done_in  = rsp_done_ff;
      rd_pend_in   = 1'b0;
      smooth_in    = smooth_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_h_in     = ram_rdata;
         rsp_done_in  = 1'b1;
      end
      if (w_finish) begin
         smooth_in    = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_h_in     = '0;
         rsp_done_in  = 1'b1;
      end
      if (accept) begin
         case (req_operation)
            hns_pkg::OP_READ:   rd_pend_in = 1'b1;
            hns_pkg::OP_SMOOTH: smooth_in  = 1'b1;
            hns_pkg::OP_WRITE: begin
               rsp_valid_in = 1'b1;
               rsp_h_in     = '0;
               rsp_done_in  = 1'b1;
            end
            default: begin
               rsp_valid_in = 1'b1;
               rsp_h_in     = '0;
               rsp_done_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         smooth_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         smooth_ff    <= smooth_in;
      end
      rsp_h_ff    <= rsp_h_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_out = rsp_h_ff;
   assign rsp_done_res   = rsp_done_ff;
endmodule
`default_nettype wire
